// File: sv/line_three_color_palette_search_assert.svh
// assertion macros for the three-color palette search block
// used by the top level, no other dependencies
`ifndef LINE_THREE_COLOR_PALETTE_SEARCH_ASSERT_SVH
`define LINE_THREE_COLOR_PALETTE_SEARCH_ASSERT_SVH

// same-cycle implication
`define LCPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LCPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lcps_pkg.sv
// shared types and constants of the three-color palette search block
// no dependencies
`default_nettype none

package lcps_pkg;

   localparam int LINE_MAX_DEF  = 256;
   localparam int PAL_DEPTH_DEF = 256;

   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int INDEX_W     = 8;
   localparam int IDX_W       = 9;
   localparam int DIST_W      = 18;
   localparam int TOT_W       = 27;
   localparam int SEL_W       = 2;
   localparam int GROUP_W     = 4 * SEL_W;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 104;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_COLOR = 1'b0,
      REG_MAX_COLOR = 1'b1
   } csr_reg_type;

   typedef enum logic {
      KIND_PALETTE = 1'b0,
      KIND_PIXEL   = 1'b1
   } kind_type;

   typedef enum logic [SEL_W-1:0] {
      SEL_A = 2'd0,
      SEL_X = 2'd1,
      SEL_Y = 2'd2
   } sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACHK,
      S_XCHK,
      S_YCHK,
      S_FA,
      S_FX,
      S_FY,
      S_PA,
      S_PX,
      S_PY,
      S_TAIL,
      S_ORD,
      S_OVAL
   } state_type;

endpackage

`default_nettype wire

// File: sv/lcps_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module lcps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/lcps_dist.sv
// shared squared rgb distance unit, result registered
// depends on lcps_pkg
`default_nettype none

module lcps_dist
   import lcps_pkg::*;
(
   input  logic               clock,
   input  logic [COLOR_W-1:0] pix,
   input  logic [COLOR_W-1:0] col,
   output logic [DIST_W-1:0]  dist_ff
);

   logic [DIST_W-1:0] dist_in;

   always_comb begin
      logic [CHAN_W-1:0]   pc;
      logic [CHAN_W-1:0]   cc;
      logic [CHAN_W-1:0]   df;
      logic [2*CHAN_W-1:0] sq;
      dist_in = '0;
      for (int k = 0; k < 3; k++) begin
         pc = pix[CHAN_W*k +: CHAN_W];
         cc = col[CHAN_W*k +: CHAN_W];
         df = (pc > cc) ? (pc - cc) : (cc - pc);
         sq = (2*CHAN_W)'(df) * (2*CHAN_W)'(df);
         dist_in = dist_in + DIST_W'(sq);
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

endmodule

`default_nettype wire

// File: sv/line_three_color_palette_search.sv
// Palette entries and one line of pixels are loaded through the request stream; a
// pixel marked last starts an exhaustive search over color triples A < X < Y with
// indices in steps of two from min_color to below the lesser of max_color and the
// palette depth. A palette write or a non-last pixel leaves the request side ready
// for the next one. The search runs on one squared-distance unit that scores one
// pixel against one color per cycle; a triple is dropped early once its partial sum
// reaches the best total, and a final pass recomputes the selects of the winner.
// After the first select read, results leave one group of four pixels per cycle
// while rsp_tready is high. The request side is not ready from the last pixel until
// the final result is taken. There is no clearing pass after reset.
// depends on lcps_pkg, lcps_ram, lcps_dist and the assertion macro header
`default_nettype none
`include "line_three_color_palette_search_assert.svh"

module line_three_color_palette_search
   import lcps_pkg::*;
#(
   parameter int LINE_MAX      = LINE_MAX_DEF,
   parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // palette_index, color
   input  logic                  req_tuser,   // kind
   input  logic                  req_tlast,   // last_pixel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sel0, sel1, sel2, sel3, a_index, x_index, y_index, a_rgb, x_rgb, y_rgb
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // found
   output logic                  rsp_tlast,   // last
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LAW       = $clog2(LINE_MAX);
   localparam int CW        = $clog2(LINE_MAX + 1);
   localparam int PAW       = $clog2(PALETTE_DEPTH);
   localparam int GRP_DEPTH = (LINE_MAX + 3) / 4;
   localparam int GAW       = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
   localparam int GCW       = $clog2(GRP_DEPTH + 1);

   localparam logic [IDX_W-1:0] PAL_HI    = IDX_W'(PALETTE_DEPTH);
   localparam logic [CW-1:0]    LINE_FULL = CW'(LINE_MAX);

   state_type state_ff, state_in;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [INDEX_W-1:0] min_color_ff, min_color_in;
   logic [IDX_W-1:0]   max_color_ff, max_color_in;
   logic [IDX_W-1:0]   a_ff, a_in, x_ff, x_in, y_ff, y_in;
   logic [INDEX_W-1:0] ba_ff, ba_in, bx_ff, bx_in, by_ff, by_in;
   logic               best_none_ff, best_none_in;
   logic               final_ff, final_in;
   logic [TOT_W-1:0]   best_dist_ff, best_dist_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [COLOR_W-1:0] a_rgb_ff, a_rgb_in, x_rgb_ff, x_rgb_in, y_rgb_ff, y_rgb_in;
   logic [LAW-1:0]     p_ff, p_in;
   logic [DIST_W-1:0]  min_ff, min_in;
   logic [SEL_W-1:0]   s_ff, s_in;
   logic [GROUP_W-1:0] grp_ff, grp_in;
   logic [GCW-1:0]     gw_ff, gw_in;
   logic [GCW-1:0]     g_ff, g_in;

   logic               req_accept;
   logic [INDEX_W-1:0] req_index;
   logic [COLOR_W-1:0] req_color;
   logic [IDX_W-1:0]   hi;

   logic               pal_wr_en;
   logic               pal_rd_en;
   logic [IDX_W-1:0]   pal_rd_addr;
   logic [COLOR_W-1:0] pal_rd_data;
   logic               line_wr_en;
   logic               line_rd_en;
   logic [CW-1:0]      line_rd_addr;
   logic [COLOR_W-1:0] line_rd_data;
   logic               sel_wr_en;
   logic               sel_rd_en;
   logic [GCW-1:0]     sel_rd_addr;
   logic [GROUP_W-1:0] sel_rd_data;

   logic [COLOR_W-1:0] dist_col;
   logic [DIST_W-1:0]  dist_ff;

   logic               y_win;
   logic [SEL_W-1:0]   acc_sel;
   logic [SEL_W-1:0]   sel_val;
   logic [DIST_W-1:0]  acc_min;
   logic [TOT_W-1:0]   acc_sum;
   logic [CW-1:0]      widx;
   logic [GROUP_W-1:0] grp_word;
   logic               grp_flush;
   logic               best_upd;
   logic               out_last;
   logic               found;

   assign req_accept = req_tvalid && req_tready;
   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_color  = req_tdata[INDEX_W +: COLOR_W];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   assign hi = (max_color_ff > PAL_HI) ? PAL_HI : max_color_ff;

   assign pal_wr_en  = req_accept && (req_tuser == KIND_PALETTE)
                       && ({1'b0, req_index} < PAL_HI);
   assign line_wr_en = req_accept && (req_tuser == KIND_PIXEL) && (cnt_ff < LINE_FULL);

   lcps_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_index[PAW-1:0]),
      .wr_data (req_color),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr[PAW-1:0]),
      .rd_data (pal_rd_data)
   );

   lcps_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (LINE_MAX)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (cnt_ff[LAW-1:0]),
      .wr_data (req_color),
      .rd_en   (line_rd_en),
      .rd_addr (line_rd_addr[LAW-1:0]),
      .rd_data (line_rd_data)
   );

   lcps_ram #(
      .WIDTH (GROUP_W),
      .DEPTH (GRP_DEPTH)
   ) u_sel_ram (
      .clock   (clock),
      .wr_en   (sel_wr_en),
      .wr_addr (gw_ff[GAW-1:0]),
      .wr_data (grp_word),
      .rd_en   (sel_rd_en),
      .rd_addr (sel_rd_addr[GAW-1:0]),
      .rd_data (sel_rd_data)
   );

   always_comb begin
      unique case (state_ff)
         S_PA:    dist_col = a_rgb_ff;
         S_PX:    dist_col = x_rgb_ff;
         default: dist_col = y_rgb_ff;
      endcase
   end

   lcps_dist u_dist (
      .clock   (clock),
      .pix     (line_rd_data),
      .col     (dist_col),
      .dist_ff (dist_ff)
   );

   // closing a pixel: fold in the y distance
   assign y_win   = dist_ff < min_ff;
   assign acc_sel = y_win ? SEL_Y : s_ff;
   assign acc_min = y_win ? dist_ff : min_ff;
   assign acc_sum = total_ff + TOT_W'(acc_min);
   assign sel_val = best_none_ff ? SEL_A : acc_sel;
   assign widx    = (state_ff == S_TAIL) ? CW'(p_ff) : (CW'(p_ff) - CW'(1));
   assign grp_flush = (widx[1:0] == 2'd3) || (widx == (cnt_ff - CW'(1)));
   assign best_upd  = (state_ff == S_TAIL) && !final_ff
                      && (best_none_ff || (acc_sum < best_dist_ff));

   always_comb begin
      grp_word = grp_ff;
      case (widx[1:0])
         2'd0:    grp_word[1:0] = sel_val;
         2'd1:    grp_word[3:2] = sel_val;
         2'd2:    grp_word[5:4] = sel_val;
         default: grp_word[7:6] = sel_val;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      min_color_in = min_color_ff;
      max_color_in = max_color_ff;
      a_in         = a_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ba_in        = ba_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      best_none_in = best_none_ff;
      final_in     = final_ff;
      best_dist_in = best_dist_ff;
      total_in     = total_ff;
      a_rgb_in     = a_rgb_ff;
      x_rgb_in     = x_rgb_ff;
      y_rgb_in     = y_rgb_ff;
      p_in         = p_ff;
      min_in       = min_ff;
      s_in         = s_ff;
      grp_in       = grp_ff;
      gw_in        = gw_ff;
      g_in         = g_ff;
      pal_rd_en    = 1'b0;
      pal_rd_addr  = a_ff;
      line_rd_en   = 1'b0;
      line_rd_addr = '0;
      sel_wr_en    = 1'b0;
      sel_rd_en    = 1'b0;
      sel_rd_addr  = g_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MIN_COLOR: min_color_in = csr_wdata[INDEX_W-1:0];
            REG_MAX_COLOR: max_color_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == KIND_PIXEL)) begin
               if (cnt_ff < LINE_FULL) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               if (req_tlast) begin
                  a_in         = {1'b0, min_color_ff};
                  best_none_in = 1'b1;
                  final_in     = 1'b0;
                  ba_in        = '0;
                  bx_in        = '0;
                  by_in        = '0;
                  state_in     = S_ACHK;
               end
            end
         end
         S_ACHK: begin
            if (a_ff < hi) begin
               x_in     = a_ff + IDX_W'(2);
               state_in = S_XCHK;
            end else begin
               final_in = 1'b1;
               gw_in    = '0;
               grp_in   = '0;
               state_in = S_FA;
            end
         end
         S_XCHK: begin
            if (x_ff < hi) begin
               y_in     = x_ff + IDX_W'(2);
               state_in = S_YCHK;
            end else begin
               a_in     = a_ff + IDX_W'(2);
               state_in = S_ACHK;
            end
         end
         S_YCHK: begin
            if (y_ff < hi) begin
               state_in = S_FA;
            end else begin
               x_in     = x_ff + IDX_W'(2);
               state_in = S_XCHK;
            end
         end
         S_FA: begin
            pal_rd_en   = 1'b1;
            pal_rd_addr = final_ff ? {1'b0, ba_ff} : a_ff;
            state_in    = S_FX;
         end
         S_FX: begin
            pal_rd_en   = 1'b1;
            pal_rd_addr = final_ff ? {1'b0, bx_ff} : x_ff;
            a_rgb_in    = pal_rd_data;
            state_in    = S_FY;
         end
         S_FY: begin
            pal_rd_en    = 1'b1;
            pal_rd_addr  = final_ff ? {1'b0, by_ff} : y_ff;
            x_rgb_in     = pal_rd_data;
            line_rd_en   = 1'b1;
            line_rd_addr = '0;
            p_in         = '0;
            total_in     = '0;
            state_in     = S_PA;
         end
         S_PA: begin
            y_rgb_in = pal_rd_data;
            if (p_ff != '0) begin
               total_in = acc_sum;
               if (final_ff) begin
                  sel_wr_en = grp_flush;
                  grp_in    = grp_flush ? '0 : grp_word;
                  if (grp_flush) begin
                     gw_in = gw_ff + GCW'(1);
                  end
               end
            end
            state_in = S_PX;
         end
         S_PX: begin
            min_in = dist_ff;
            s_in   = SEL_A;
            if (!final_ff && !best_none_ff && (total_ff >= best_dist_ff)) begin
               y_in     = y_ff + IDX_W'(2);
               state_in = S_YCHK;
            end else begin
               state_in = S_PY;
            end
         end
         S_PY: begin
            if (dist_ff < min_ff) begin
               min_in = dist_ff;
               s_in   = SEL_X;
            end
            if ((CW'(p_ff) + CW'(1)) < cnt_ff) begin
               line_rd_en   = 1'b1;
               line_rd_addr = CW'(p_ff) + CW'(1);
               p_in         = p_ff + LAW'(1);
               state_in     = S_PA;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (final_ff) begin
               sel_wr_en = 1'b1;
               grp_in    = '0;
               gw_in     = gw_ff + GCW'(1);
               g_in      = '0;
               state_in  = S_ORD;
            end else begin
               if (best_upd) begin
                  best_dist_in = acc_sum;
                  best_none_in = 1'b0;
                  ba_in        = a_ff[INDEX_W-1:0];
                  bx_in        = x_ff[INDEX_W-1:0];
                  by_in        = y_ff[INDEX_W-1:0];
               end
               y_in     = y_ff + IDX_W'(2);
               state_in = S_YCHK;
            end
         end
         S_ORD: begin
            sel_rd_en   = 1'b1;
            sel_rd_addr = g_ff;
            state_in    = S_OVAL;
         end
         S_OVAL: begin
            if (rsp_tready) begin
               if (out_last) begin
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  sel_rd_en   = 1'b1;
                  sel_rd_addr = g_ff + GCW'(1);
                  g_in        = g_ff + GCW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         min_color_ff <= '0;
         max_color_ff <= IDX_W'(256);
         best_none_ff <= 1'b1;
         final_ff     <= 1'b0;
         gw_ff        <= '0;
         g_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         min_color_ff <= min_color_in;
         max_color_ff <= max_color_in;
         best_none_ff <= best_none_in;
         final_ff     <= final_in;
         gw_ff        <= gw_in;
         g_ff         <= g_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      ba_ff        <= ba_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      best_dist_ff <= best_dist_in;
      total_ff     <= total_in;
      a_rgb_ff     <= a_rgb_in;
      x_rgb_ff     <= x_rgb_in;
      y_rgb_ff     <= y_rgb_in;
      p_ff         <= p_in;
      min_ff       <= min_in;
      s_ff         <= s_in;
      grp_ff       <= grp_in;
   end

   // result transfer
   assign found      = !best_none_ff;
   assign out_last   = (g_ff + GCW'(1)) == gw_ff;
   assign rsp_tvalid = (state_ff == S_OVAL);
   assign rsp_tlast  = out_last;
   assign rsp_tuser  = found;
   assign rsp_tdata  = {
      (found ? y_rgb_ff : {COLOR_W{1'b0}}),
      (found ? x_rgb_ff : {COLOR_W{1'b0}}),
      (found ? a_rgb_ff : {COLOR_W{1'b0}}),
      (found ? by_ff : {INDEX_W{1'b0}}),
      (found ? bx_ff : {INDEX_W{1'b0}}),
      (found ? ba_ff : {INDEX_W{1'b0}}),
      sel_rd_data
   };

   `LCPS_ASSERT_NOW(a_no_req_while_rsp, clock, reset, rsp_tvalid, !req_tready,
      "request taken while results pending")
   `LCPS_ASSERT_NOW(a_triple_order, clock, reset, (state_ff == S_PA) && !final_ff,
      (x_ff > a_ff) && (y_ff > x_ff), "triple indices out of order")
   `LCPS_ASSERT_NEXT(a_best_shrinks, clock, reset, best_upd && !best_none_ff,
      best_dist_ff < $past(best_dist_ff), "best total did not decrease")
   `LCPS_ASSERT_NOW(a_group_range, clock, reset, rsp_tvalid, g_ff < gw_ff,
      "result group beyond written groups")
   `LCPS_ASSERT_NEXT(a_line_done, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      (state_ff == S_IDLE) && (cnt_ff == '0), "line not cleared after final result")

endmodule

`default_nettype wire
